// File: sv/svs_pkg.sv
// Shared types, constants and codes for the scheduled valve sequencer.
`timescale 1ns / 1ps
`default_nettype none
package svs_pkg;

    localparam int NUM_CHANNELS  = 4;
    localparam int NUM_SCHEDULES = 3;
    localparam int TIME_W        = 32;

    // channel index runs 0..NUM_CHANNELS, the top value meaning "past the last"
    localparam int CH_IDX_W = $clog2(NUM_CHANNELS + 1);
    localparam int CH_SEL_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // calendar field widths on the input item
    localparam int MIN_W  = 6;
    localparam int HOUR_W = 5;
    localparam int DOM_W  = 5;
    localparam int MON_W  = 4;
    localparam int DOW_W  = 3;

    // packed schedule layout
    localparam int SCHED_W     = 28;
    localparam int S_MIN_W     = 7;
    localparam int S_HOUR_W    = 6;
    localparam int S_DOM_W     = 6;
    localparam int S_MON_W     = 5;
    localparam int S_DOW_W     = 4;
    localparam int S_MIN_LSB   = 0;
    localparam int S_HOUR_LSB  = S_MIN_LSB + S_MIN_W;
    localparam int S_DOM_LSB   = S_HOUR_LSB + S_HOUR_W;
    localparam int S_MON_LSB   = S_DOM_LSB + S_DOM_W;
    localparam int S_DOW_LSB   = S_MON_LSB + S_MON_W;
    localparam logic [S_MIN_W-1:0]  WILD_MIN  = '1;
    localparam logic [S_HOUR_W-1:0] WILD_HOUR = '1;
    localparam logic [S_DOM_W-1:0]  WILD_DOM  = '1;
    localparam logic [S_MON_W-1:0]  WILD_MON  = '1;
    localparam logic [S_DOW_W-1:0]  WILD_DOW  = '1;

    localparam int CATCH_W = 6;

    // register map
    localparam int APB_DATA_W = 32;
    localparam int REG_COUNT  = NUM_SCHEDULES + 4;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int APB_ADDR_W = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_CH_ENABLE = REG_IDX_W'(NUM_SCHEDULES);
    localparam logic [REG_IDX_W-1:0] REG_OPEN_DUR  = REG_IDX_W'(NUM_SCHEDULES + 1);
    localparam logic [REG_IDX_W-1:0] REG_CHECK_INT = REG_IDX_W'(NUM_SCHEDULES + 2);
    localparam logic [REG_IDX_W-1:0] REG_CATCH_UP  = REG_IDX_W'(NUM_SCHEDULES + 3);

    localparam logic [SCHED_W-1:0]      SCHED_RESET    = 28'd268428032;
    localparam logic [NUM_CHANNELS-1:0] CH_EN_RESET    = '1;
    localparam logic [TIME_W-1:0]       OPEN_DUR_RESET = TIME_W'(60000);
    localparam logic [TIME_W-1:0]       CHECK_RESET    = TIME_W'(60000);
    localparam logic [CATCH_W-1:0]      CATCH_RESET    = CATCH_W'(1);

    // stream widths
    localparam int ACTION_W  = 2;
    localparam int IN_DATA_W = 56;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_START = 2'd2
    } action_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TIME_W-1:0]   now_ms;
        logic [MIN_W-1:0]    minute;
        logic [HOUR_W-1:0]   hour;
        logic [DOM_W-1:0]    day_of_month;
        logic [MON_W-1:0]    month;
        logic [DOW_W-1:0]    day_of_week;
    } item_t;

    typedef struct packed {
        logic [NUM_SCHEDULES-1:0][SCHED_W-1:0] schedule;
        logic [NUM_CHANNELS-1:0]               channel_enable;
        logic [TIME_W-1:0]                     open_duration_ms;
        logic [TIME_W-1:0]                     check_interval_ms;
        logic [CATCH_W-1:0]                    catch_up_minutes;
    } cfg_t;

    typedef struct packed {
        logic [NUM_CHANNELS-1:0] valves_open;
        logic                    running;
        logic [CH_IDX_W-1:0]     active_channel;
        logic                    state_report;
    } result_t;

endpackage
`default_nettype wire

// File: sv/svs_cfg_regs.sv
// APB configuration register file for the valve sequencer.
`timescale 1ns / 1ps
`default_nettype none
module svs_cfg_regs
    import svs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            for (int i = 0; i < NUM_SCHEDULES; i++)
            begin
                if (reg_idx == REG_IDX_W'(i))
                begin
                    cfg_next.schedule[i] = pwdata[SCHED_W-1:0];
                end
            end
            if (reg_idx == REG_CH_ENABLE)
            begin
                cfg_next.channel_enable = pwdata[NUM_CHANNELS-1:0];
            end
            if (reg_idx == REG_OPEN_DUR)
            begin
                cfg_next.open_duration_ms = pwdata[TIME_W-1:0];
            end
            if (reg_idx == REG_CHECK_INT)
            begin
                cfg_next.check_interval_ms = pwdata[TIME_W-1:0];
            end
            if (reg_idx == REG_CATCH_UP)
            begin
                cfg_next.catch_up_minutes = pwdata[CATCH_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        for (int i = 0; i < NUM_SCHEDULES; i++)
        begin
            if (reg_idx == REG_IDX_W'(i))
            begin
                prdata = APB_DATA_W'(cfg_reg.schedule[i]);
            end
        end
        if (reg_idx == REG_CH_ENABLE)
        begin
            prdata = APB_DATA_W'(cfg_reg.channel_enable);
        end
        if (reg_idx == REG_OPEN_DUR)
        begin
            prdata = APB_DATA_W'(cfg_reg.open_duration_ms);
        end
        if (reg_idx == REG_CHECK_INT)
        begin
            prdata = APB_DATA_W'(cfg_reg.check_interval_ms);
        end
        if (reg_idx == REG_CATCH_UP)
        begin
            prdata = APB_DATA_W'(cfg_reg.catch_up_minutes);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SCHEDULES; i++)
            begin
                cfg_reg.schedule[i] <= SCHED_RESET;
            end
            cfg_reg.channel_enable    <= CH_EN_RESET;
            cfg_reg.open_duration_ms  <= OPEN_DUR_RESET;
            cfg_reg.check_interval_ms <= CHECK_RESET;
            cfg_reg.catch_up_minutes  <= CATCH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/svs_sched_match.sv
// Parallel calendar match of all packed schedules against one item.
`timescale 1ns / 1ps
`default_nettype none
module svs_sched_match
    import svs_pkg::*;
(
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output logic       hit
);

    logic [NUM_SCHEDULES-1:0] sched_hit;

    always_comb
    begin
        logic [S_MIN_W-1:0]  s_min;
        logic [S_HOUR_W-1:0] s_hour;
        logic [S_DOM_W-1:0]  s_dom;
        logic [S_MON_W-1:0]  s_mon;
        logic [S_DOW_W-1:0]  s_dow;
        logic [S_MIN_W:0]    min_hi;
        logic                min_ok;
        for (int i = 0; i < NUM_SCHEDULES; i++)
        begin
            s_min  = cfg.schedule[i][S_MIN_LSB  +: S_MIN_W];
            s_hour = cfg.schedule[i][S_HOUR_LSB +: S_HOUR_W];
            s_dom  = cfg.schedule[i][S_DOM_LSB  +: S_DOM_W];
            s_mon  = cfg.schedule[i][S_MON_LSB  +: S_MON_W];
            s_dow  = cfg.schedule[i][S_DOW_LSB  +: S_DOW_W];
            // catch-up window: scheduled minute up to minute + catch_up inclusive
            min_hi = {1'b0, s_min} + (S_MIN_W + 1)'(cfg.catch_up_minutes);
            min_ok = (s_min == WILD_MIN) ||
                     ((S_MIN_W'(item.minute) >= s_min) &&
                      ((S_MIN_W + 1)'(item.minute) <= min_hi));
            sched_hit[i] = min_ok &&
                ((s_hour == WILD_HOUR) || (s_hour == S_HOUR_W'(item.hour))) &&
                ((s_dom  == WILD_DOM)  || (s_dom  == S_DOM_W'(item.day_of_month))) &&
                ((s_mon  == WILD_MON)  || (s_mon  == S_MON_W'(item.month))) &&
                ((s_dow  == WILD_DOW)  || (s_dow  == S_DOW_W'(item.day_of_week)));
        end
    end

    assign hit = |sched_hit;

endmodule
`default_nettype wire

// File: sv/svs_core.sv
// Sequencer state and the per-item update of run, channel and valve state.
`timescale 1ns / 1ps
`default_nettype none
module svs_core
    import svs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    input  wire logic  hit,
    output result_t    result
);

    logic                    run_active_reg;
    logic                    run_active_next;
    logic [CH_IDX_W-1:0]     channel_index_reg;
    logic [CH_IDX_W-1:0]     channel_index_next;
    logic [NUM_CHANNELS-1:0] valve_bits_reg;
    logic [NUM_CHANNELS-1:0] valve_bits_next;
    logic [TIME_W-1:0]       open_since_reg;
    logic [TIME_W-1:0]       open_since_next;
    logic [TIME_W-1:0]       last_check_reg;
    logic [TIME_W-1:0]       last_check_next;
    logic                    first_check_reg;
    logic                    first_check_next;
    logic                    report;

    logic [CH_SEL_W-1:0] ch_sel;
    logic                ch_valid;
    logic [TIME_W-1:0]   since_check;
    logic [TIME_W-1:0]   since_open;

    assign ch_sel      = channel_index_reg[CH_SEL_W-1:0];
    assign ch_valid    = channel_index_reg < CH_IDX_W'(NUM_CHANNELS);
    assign since_check = item.now_ms - last_check_reg;
    assign since_open  = item.now_ms - open_since_reg;

    always_comb
    begin
        run_active_next    = run_active_reg;
        channel_index_next = channel_index_reg;
        valve_bits_next    = valve_bits_reg;
        open_since_next    = open_since_reg;
        last_check_next    = last_check_reg;
        first_check_next   = first_check_reg;
        report             = 1'b0;

        unique case (item.action)
            ACT_TICK:
            begin
                priority if (!run_active_reg)
                begin
                    if (first_check_reg || (since_check > cfg.check_interval_ms))
                    begin
                        first_check_next = 1'b0;
                        last_check_next  = item.now_ms;
                        if (hit)
                        begin
                            run_active_next    = 1'b1;
                            channel_index_next = '0;
                            report             = 1'b1;
                        end
                    end
                end
                else if (!ch_valid)
                begin
                    run_active_next = 1'b0;
                    report          = 1'b1;
                end
                else if (!cfg.channel_enable[ch_sel])
                begin
                    channel_index_next = channel_index_reg + 1'b1;
                end
                else if (!valve_bits_reg[ch_sel])
                begin
                    valve_bits_next[ch_sel] = 1'b1;
                    open_since_next         = item.now_ms;
                end
                else if (since_open >= cfg.open_duration_ms)
                begin
                    valve_bits_next[ch_sel] = 1'b0;
                    channel_index_next      = channel_index_reg + 1'b1;
                end
                else
                begin
                end
            end
            ACT_STOP:
            begin
                report = 1'b1;
                if (run_active_reg)
                begin
                    if (ch_valid)
                    begin
                        valve_bits_next[ch_sel] = 1'b0;
                    end
                    run_active_next = 1'b0;
                end
            end
            ACT_START:
            begin
                report = 1'b1;
                if (!run_active_reg)
                begin
                    run_active_next    = 1'b1;
                    channel_index_next = '0;
                end
            end
            default:
            begin
                // unused action code: state holds, still reported
                report = 1'b1;
            end
        endcase
    end

    assign result.valves_open    = valve_bits_next;
    assign result.running        = run_active_next;
    assign result.active_channel = channel_index_next;
    assign result.state_report   = report;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg    <= 1'b0;
            channel_index_reg <= '0;
            valve_bits_reg    <= '0;
            open_since_reg    <= '0;
            last_check_reg    <= '0;
            first_check_reg   <= 1'b1;
        end
        else if (advance)
        begin
            run_active_reg    <= run_active_next;
            channel_index_reg <= channel_index_next;
            valve_bits_reg    <= valve_bits_next;
            open_since_reg    <= open_since_next;
            last_check_reg    <= last_check_next;
            first_check_reg   <= first_check_next;
        end
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        channel_index_reg <= CH_IDX_W'(NUM_CHANNELS))
        else $error("channel index beyond last channel");

    a_one_valve: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(valve_bits_reg))
        else $error("more than one valve open");

    a_open_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        (valve_bits_reg != '0) |-> (run_active_reg && ch_valid && valve_bits_reg[ch_sel]))
        else $error("open valve outside the current channel of a run");

    a_first_check: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(first_check_reg) |-> $past(advance && item.action == ACT_TICK))
        else $error("first check cleared without a tick");

endmodule
`default_nettype wire

// File: sv/scheduled_valve_sequencer.sv
// Scheduled valve sequencer: top level with stream stages and APB config.
//
// Items come in on the s_axis channel: tuser carries the action (tick, stop,
// start), tdata the millisecond time and calendar fields. Each accepted item
// gives exactly one result on the m_axis channel: the valve bits, the run
// flag, the current channel index and a report flag.
// An accepted item is held in the input register; the state update and
// schedule compare run between that register and the result register,
// from which the result is offered on m_axis. Throughput is one item per
// cycle while m_axis_tready keeps the result register free; the state
// registers update as the item moves to the result register, so the next
// item sees them at once.
// When m_axis_tready is low, the result register holds and the input register
// still takes one more item; only then does s_axis_tready fall.
// Reset clears both stages, closes all valves, stops any run, arms the first
// schedule check and loads the register defaults. Registers are written over
// APB at byte address 4*i; write them only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module scheduled_valve_sequencer
    import svs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [31:0] now_ms, [37:32] minute, [42:38] hour, [47:43] day_of_month,
    // [51:48] month, [54:52] day_of_week
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  wire logic [ACTION_W-1:0]   s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [3:0] valves_open, [4] running, [7:5] active_channel, [8] state_report
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int F_MIN_LSB  = TIME_W;
    localparam int F_HOUR_LSB = F_MIN_LSB + MIN_W;
    localparam int F_DOM_LSB  = F_HOUR_LSB + HOUR_W;
    localparam int F_MON_LSB  = F_DOM_LSB + DOM_W;
    localparam int F_DOW_LSB  = F_MON_LSB + MON_W;
    localparam int RES_W      = NUM_CHANNELS + 1 + CH_IDX_W + 1;

    cfg_t    cfg;
    item_t   in_item;
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t step_res;
    logic    hit;
    logic    advance;

    assign in_item.action       = s_axis_tuser;
    assign in_item.now_ms       = s_axis_tdata[TIME_W-1:0];
    assign in_item.minute       = s_axis_tdata[F_MIN_LSB  +: MIN_W];
    assign in_item.hour         = s_axis_tdata[F_HOUR_LSB +: HOUR_W];
    assign in_item.day_of_month = s_axis_tdata[F_DOM_LSB  +: DOM_W];
    assign in_item.month        = s_axis_tdata[F_MON_LSB  +: MON_W];
    assign in_item.day_of_week  = s_axis_tdata[F_DOW_LSB  +: DOW_W];

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    svs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    svs_sched_match u_match (
        .item (in_item_reg),
        .cfg  (cfg),
        .hit  (hit)
    );

    svs_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .hit     (hit),
        .result  (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_res_reg.state_report,
                                        out_res_reg.active_channel,
                                        out_res_reg.running,
                                        out_res_reg.valves_open});

    a_res_width: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(out_res_reg))
        else $error("stalled result changed");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are blocked");

    a_advance_fill: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg && (RES_W'(out_res_reg) == RES_W'($past(step_res))))
        else $error("result register missed an update");

endmodule
`default_nettype wire
